// ----- rtl/core/grid_move_sequence_generator_defines.svh -----
// ----------------------------------------------------------------------------
// grid move sequence generator assertion macros
// shared concurrent assertion forms for the rtl/core modules
// ----------------------------------------------------------------------------
`ifndef GRID_MOVE_SEQUENCE_GENERATOR_DEFINES_SVH
`define GRID_MOVE_SEQUENCE_GENERATOR_DEFINES_SVH

// same-cycle implication, disabled during reset
`define GMSG_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define GMSG_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/gmsg_pkg.sv -----
// ----------------------------------------------------------------------------
// gmsg_pkg
// types and constants of the grid move sequence generator
// ----------------------------------------------------------------------------
package gmsg_pkg;

  localparam int COORD_W = 4;
  localparam int TAG_W   = 16;
  localparam int STEP_W  = 5;
  localparam int MOVE_W  = 4;

  // longest plan: fifteen horizontal plus fifteen vertical moves
  localparam logic [STEP_W-1:0] MAX_STEP = 5'd29;

  typedef logic [COORD_W-1:0] coord_t;

  typedef enum logic [MOVE_W-1:0] {
    MV_NE   = 4'd0,
    MV_SE   = 4'd1,
    MV_NW   = 4'd2,
    MV_SW   = 4'd3,
    MV_E    = 4'd4,
    MV_W    = 4'd5,
    MV_N    = 4'd6,
    MV_S    = 4'd7,
    MV_UP   = 4'd8,
    MV_DOWN = 4'd9
  } move_t;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  // current cell, goal and whose turn it is
  typedef struct packed {
    coord_t pos_x;
    coord_t pos_y;
    coord_t pos_z;
    coord_t tgt_x;
    coord_t tgt_y;
    coord_t tgt_z;
    logic   turn_xy;
  } step_req_t;

  // one planned move and the cell it leads to
  typedef struct packed {
    move_t  move;
    logic   sel_xy;
    coord_t next_x;
    coord_t next_y;
    coord_t next_z;
    logic   empty;
    logic   last;
  } step_res_t;

endpackage

// ----- rtl/core/gmsg_if.sv -----
// ----------------------------------------------------------------------------
// gmsg channel interfaces
// mission request channel and move result channel, valid/ready handshake
// ----------------------------------------------------------------------------
interface gmsg_req_if;
  import gmsg_pkg::*;

  logic               valid;
  logic               ready;
  logic [COORD_W-1:0] source_x;
  logic [COORD_W-1:0] source_y;
  logic [COORD_W-1:0] source_z;
  logic [COORD_W-1:0] goal_x;
  logic [COORD_W-1:0] goal_y;
  logic [COORD_W-1:0] goal_z;
  logic [TAG_W-1:0]   mission_tag;

  modport source (
    output valid, source_x, source_y, source_z, goal_x, goal_y, goal_z, mission_tag,
    input  ready
  );

  modport sink (
    input  valid, source_x, source_y, source_z, goal_x, goal_y, goal_z, mission_tag,
    output ready
  );
endinterface

interface gmsg_res_if;
  import gmsg_pkg::*;

  logic              valid;
  logic              ready;
  logic [MOVE_W-1:0] move;
  logic [STEP_W-1:0] step_index;
  logic [TAG_W-1:0]  mission_tag_res;
  logic              empty_plan;
  logic              last;

  modport source (
    output valid, move, step_index, mission_tag_res, empty_plan, last,
    input  ready
  );

  modport sink (
    input  valid, move, step_index, mission_tag_res, empty_plan, last,
    output ready
  );
endinterface

// ----- rtl/core/grid_move_sequence_generator.sv -----
// ----------------------------------------------------------------------------
// grid_move_sequence_generator
// plans unit grid moves from a source cell to a goal cell, one per transaction
// ----------------------------------------------------------------------------
// Each request transaction carries one mission (source and goal cell, tag).
// The block answers with one result transaction per unit move: horizontal
// moves go diagonally until x or y matches, then straight; vertical moves
// step up or down; the two lists are interleaved xy, z, xy, z and a list
// that runs out is skipped. A mission whose source equals its goal gives a
// single result flagged empty_plan. The final result of a mission has last
// set. Coordinates above GRID_SIZE - 1 are saturated before planning.
// The single step unit produces one move per cycle from the current cell
// while the result side does not stall; req.ready is high only while no
// mission is being planned, and a new mission can be taken while the last
// result still waits in the output register.
// ----------------------------------------------------------------------------
`include "grid_move_sequence_generator_defines.svh"

module grid_move_sequence_generator
  import gmsg_pkg::*;
#(
  parameter int GRID_SIZE = 16
) (
  input  logic       clk,
  input  logic       rst,
  gmsg_req_if.sink   req,
  gmsg_res_if.source res
);

  // largest legal coordinate, six bits so that grid sizes up to 64 fit
  localparam logic [5:0] MAX_COORD = 6'(GRID_SIZE - 1);

  function automatic coord_t clamp(input coord_t v);
    coord_t c;
    c = v;
    if ({2'b00, v} > MAX_COORD) c = MAX_COORD[COORD_W-1:0];
    return c;
  endfunction

  // sequencer state
  state_t            state;
  state_t            state_next;
  logic              accept;
  logic              advance;
  logic              out_free;

  // mission registers
  coord_t            pos_x, pos_y, pos_z;
  coord_t            tgt_x, tgt_y, tgt_z;
  logic [TAG_W-1:0]  held_tag;
  logic [STEP_W-1:0] step_idx;
  logic              turn_xy;

  // output register
  logic              out_valid;
  move_t             out_move;
  logic [STEP_W-1:0] out_step;
  logic [TAG_W-1:0]  out_tag;
  logic              out_empty;
  logic              out_last;

  step_req_t         su_req;
  step_res_t         su_res;

  // output register frees up when empty or when its transaction completes
  assign out_free = !out_valid || res.ready;
  assign accept   = req.valid && req.ready;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (req.valid) state_next = S_RUN;
      S_RUN:  if (out_free && su_res.last) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    req.ready = 1'b0;
    advance   = 1'b0;
    unique case (state)
      S_IDLE: req.ready = 1'b1;
      S_RUN:  advance   = out_free;
      default: begin
        req.ready = 1'b0;
        advance   = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else     state <= state_next;
  end

  // shared step unit works on the current cell
  assign su_req = '{pos_x: pos_x, pos_y: pos_y, pos_z: pos_z,
                    tgt_x: tgt_x, tgt_y: tgt_y, tgt_z: tgt_z,
                    turn_xy: turn_xy};

  gmsg_step_unit u_step (
    .req (su_req),
    .res (su_res)
  );

  // mission registers: load on a new mission, walk one move per cycle while the output register is free
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x    <= clamp(req.source_x);
      pos_y    <= clamp(req.source_y);
      pos_z    <= clamp(req.source_z);
      tgt_x    <= clamp(req.goal_x);
      tgt_y    <= clamp(req.goal_y);
      tgt_z    <= clamp(req.goal_z);
      held_tag <= req.mission_tag;
      step_idx <= '0;
      turn_xy  <= 1'b1;
    end else if (advance) begin
      pos_x    <= su_res.next_x;
      pos_y    <= su_res.next_y;
      pos_z    <= su_res.next_z;
      step_idx <= step_idx + 1'b1;
      // the other list gets the next turn
      turn_xy  <= !su_res.sel_xy;
    end
  end

  // output register valid flag
  always_ff @(posedge clk) begin
    if (rst)          out_valid <= 1'b0;
    else if (advance) out_valid <= 1'b1;
    else if (res.ready) out_valid <= 1'b0;
  end

  // output payload
  always_ff @(posedge clk) begin
    if (advance) begin
      out_move  <= su_res.move;
      out_step  <= step_idx;
      out_tag   <= held_tag;
      out_empty <= su_res.empty;
      out_last  <= su_res.last;
    end
  end

  assign res.valid           = out_valid;
  assign res.move            = out_move;
  assign res.step_index      = out_step;
  assign res.mission_tag_res = out_tag;
  assign res.empty_plan      = out_empty;
  assign res.last            = out_last;

  // a pending result that is not the final one means planning is still on
  `GMSG_ASSERT_NOW(a_midplan_running, clk, rst, res.valid && !res.last, state == S_RUN,
    "non-final result pending while sequencer idle")

  // an empty plan is a single result
  `GMSG_ASSERT_NOW(a_empty_single, clk, rst, res.valid && res.empty_plan,
    res.last && (res.step_index == '0), "empty plan result is not a lone first move")

  // no plan runs past thirty moves
  `GMSG_ASSERT_NOW(a_step_bound, clk, rst, res.valid, res.step_index <= MAX_STEP,
    "step index beyond longest plan")

  // a new mission starts from the first move with the xy list
  `GMSG_ASSERT_NEXT(a_mission_start, clk, rst, accept,
    (state == S_RUN) && (step_idx == '0) && turn_xy, "mission did not start cleanly")

endmodule

// ----- rtl/core/gmsg_step_unit.sv -----
// ----------------------------------------------------------------------------
// gmsg_step_unit
// shared compare and step unit: picks the next move and the cell it reaches
// ----------------------------------------------------------------------------
module gmsg_step_unit
  import gmsg_pkg::*;
(
  input  step_req_t req,
  output step_res_t res
);

  logic  xy_done;
  logic  z_done;
  logic  sel_xy;
  logic  xp, xn, yp, yn, zp;
  move_t xy_move;
  move_t z_move;

  assign xy_done = (req.pos_x == req.tgt_x) && (req.pos_y == req.tgt_y);
  assign z_done  = (req.pos_z == req.tgt_z);

  // take the side whose turn it is, unless it has nothing left
  assign sel_xy = req.turn_xy ? !xy_done : z_done;

  assign xp = req.tgt_x > req.pos_x;
  assign xn = req.tgt_x < req.pos_x;
  assign yp = req.tgt_y > req.pos_y;
  assign yn = req.tgt_y < req.pos_y;
  assign zp = req.tgt_z > req.pos_z;

  always_comb begin
    if (xp && yp)      xy_move = MV_NE;
    else if (xp && yn) xy_move = MV_SE;
    else if (xn && yp) xy_move = MV_NW;
    else if (xn && yn) xy_move = MV_SW;
    else if (xp)       xy_move = MV_E;
    else if (xn)       xy_move = MV_W;
    else if (yp)       xy_move = MV_N;
    else               xy_move = MV_S;
  end

  assign z_move = zp ? MV_UP : MV_DOWN;

  always_comb begin
    res.sel_xy = sel_xy;
    res.empty  = xy_done && z_done;
    res.next_x = req.pos_x;
    res.next_y = req.pos_y;
    res.next_z = req.pos_z;
    if (res.empty) begin
      res.move = MV_NE;
    end else if (sel_xy) begin
      res.move = xy_move;
      if (xp) res.next_x = req.pos_x + 1'b1;
      if (xn) res.next_x = req.pos_x - 1'b1;
      if (yp) res.next_y = req.pos_y + 1'b1;
      if (yn) res.next_y = req.pos_y - 1'b1;
    end else begin
      res.move   = z_move;
      res.next_z = zp ? req.pos_z + 1'b1 : req.pos_z - 1'b1;
    end
    res.last = res.empty ||
               ((res.next_x == req.tgt_x) && (res.next_y == req.tgt_y) &&
                (res.next_z == req.tgt_z));
  end

endmodule

// ----- tb/sv/tb_grid_move_sequence_generator.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_grid_move_sequence_generator
// Drives missions into the grid move sequence generator and checks every
// move transaction against a behavioural planner kept inside the bench, or
// against a typed row's move. A short table of directed missions runs first,
// then randomised missions, with random request gaps and result stalls.
// ----------------------------------------------------------------------------
module tb_grid_move_sequence_generator;
  import gmsg_pkg::*;

  localparam int GRID_SIZE    = 16;
  localparam int RANDOM_COUNT = 460;
  localparam int DRAIN_CYCLES = 40;         // one full mission plus margin
  localparam int CYCLE_LIMIT  = 1_200_000;  // about four times the slowest run
  localparam int REPORT_MAX   = 10;

  // one row of the directed table; typed rows carry their single move
  typedef struct packed {
    coord_t           sx;
    coord_t           sy;
    coord_t           sz;
    coord_t           gx;
    coord_t           gy;
    coord_t           gz;
    logic [TAG_W-1:0] tag;
    logic             typed;
    move_t            t_move;
    logic             t_empty;
  } mission_row_t;

  // one expected move transaction
  typedef struct {
    move_t             move;
    logic [STEP_W-1:0] step;
    logic [TAG_W-1:0]  tag;
    logic              empty;
    logic              last;
  } planned_move_t;

  localparam int DIRECTED_COUNT = 23;

  // directed missions: empty plans, each single move, corners and long legs
  localparam mission_row_t DIRECTED [0:DIRECTED_COUNT-1] = '{
    // empty plan straight after reset, all-zero tag
    '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  16'h0000, 1'b1, MV_NE,   1'b1},
    // empty plan in the far corner, all-ones tag
    '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 16'hffff, 1'b1, MV_NE,   1'b1},
    // a single step in each direction
    '{4'd0,  4'd0,  4'd0,  4'd1,  4'd1,  4'd0,  16'h0101, 1'b1, MV_NE,   1'b0},
    '{4'd0,  4'd1,  4'd0,  4'd1,  4'd0,  4'd0,  16'h0202, 1'b1, MV_SE,   1'b0},
    '{4'd1,  4'd0,  4'd0,  4'd0,  4'd1,  4'd0,  16'h0303, 1'b1, MV_NW,   1'b0},
    '{4'd1,  4'd1,  4'd0,  4'd0,  4'd0,  4'd0,  16'h0404, 1'b1, MV_SW,   1'b0},
    '{4'd0,  4'd0,  4'd0,  4'd1,  4'd0,  4'd0,  16'h0505, 1'b1, MV_E,    1'b0},
    '{4'd1,  4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  16'h0606, 1'b1, MV_W,    1'b0},
    '{4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  4'd0,  16'h0707, 1'b1, MV_N,    1'b0},
    '{4'd0,  4'd1,  4'd0,  4'd0,  4'd0,  4'd0,  16'h0808, 1'b1, MV_S,    1'b0},
    '{4'd0,  4'd0,  4'd0,  4'd0,  4'd0,  4'd1,  16'h0909, 1'b1, MV_UP,   1'b0},
    '{4'd0,  4'd0,  4'd1,  4'd0,  4'd0,  4'd0,  16'h0a0a, 1'b1, MV_DOWN, 1'b0},
    // longest plans, corner to corner
    '{4'd0,  4'd0,  4'd0,  4'd15, 4'd15, 4'd15, 16'ha5a5, 1'b0, MV_NE,   1'b0},
    '{4'd15, 4'd15, 4'd15, 4'd0,  4'd0,  4'd0,  16'h5a5a, 1'b0, MV_NE,   1'b0},
    '{4'd0,  4'd15, 4'd0,  4'd15, 4'd0,  4'd15, 16'hc3c3, 1'b0, MV_NE,   1'b0},
    '{4'd15, 4'd0,  4'd15, 4'd0,  4'd15, 4'd0,  16'h3c3c, 1'b0, MV_NE,   1'b0},
    // diagonal leg then straight leg
    '{4'd0,  4'd0,  4'd0,  4'd15, 4'd3,  4'd0,  16'h1111, 1'b0, MV_NE,   1'b0},
    '{4'd12, 4'd14, 4'd2,  4'd1,  4'd2,  4'd9,  16'h2222, 1'b0, MV_NE,   1'b0},
    // straight only, and vertical only
    '{4'd3,  4'd0,  4'd7,  4'd3,  4'd15, 4'd7,  16'h4444, 1'b0, MV_NE,   1'b0},
    '{4'd7,  4'd7,  4'd0,  4'd7,  4'd7,  4'd15, 16'h8000, 1'b0, MV_NE,   1'b0},
    '{4'd15, 4'd15, 4'd15, 4'd15, 4'd15, 4'd0,  16'h0001, 1'b0, MV_NE,   1'b0},
    // short vertical list against a long horizontal one
    '{4'd2,  4'd9,  4'd12, 4'd14, 4'd1,  4'd10, 16'h1234, 1'b0, MV_NE,   1'b0},
    '{4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  4'd9,  16'hfffe, 1'b1, MV_NE,   1'b1}
  };

  logic clk;
  logic rst;

  gmsg_req_if req_ch ();
  gmsg_res_if res_ch ();

  grid_move_sequence_generator #(
    .GRID_SIZE (GRID_SIZE)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .res (res_ch)
  );

  // expected moves, oldest at the front
  planned_move_t planned_moves [$];

  // planner state: current cell, goal and length of the latest plan
  coord_t            cur_x, cur_y, cur_z;
  coord_t            aim_x, aim_y, aim_z;
  int                plan_len;

  // typed expectation of the mission now on the request channel
  logic              row_typed;
  move_t             row_move;
  logic              row_empty;

  int                mismatch_count;
  int                cycle_count;
  int                sink_wait;
  logic              sink_calm;
  logic              sender_calm;

  // coordinates beyond the grid saturate to its last cell
  function automatic coord_t saturate(input coord_t c);
    if (int'(c) > GRID_SIZE - 1) begin
      return coord_t'(GRID_SIZE - 1);
    end
    return c;
  endfunction

  // works out the whole plan of one mission and queues its moves
  function automatic void plan_mission(input coord_t sx, input coord_t sy, input coord_t sz,
                                       input coord_t gx, input coord_t gy, input coord_t gz,
                                       input logic [TAG_W-1:0] tag);
    move_t         flat_list [$];
    move_t         lift_list [$];
    planned_move_t pm;
    logic          xp, xn, yp, yn;
    int            i, j, n;
    cur_x    = saturate(sx);
    cur_y    = saturate(sy);
    cur_z    = saturate(sz);
    aim_x    = saturate(gx);
    aim_y    = saturate(gy);
    aim_z    = saturate(gz);

    // horizontal leg: diagonal while both axes differ, then straight
    while (cur_x != aim_x || cur_y != aim_y) begin
      xp = aim_x > cur_x;
      xn = aim_x < cur_x;
      yp = aim_y > cur_y;
      yn = aim_y < cur_y;
      if (xp && yp) flat_list.insert(flat_list.size(), MV_NE);
      else if (xp && yn) flat_list.insert(flat_list.size(), MV_SE);
      else if (xn && yp) flat_list.insert(flat_list.size(), MV_NW);
      else if (xn && yn) flat_list.insert(flat_list.size(), MV_SW);
      else if (xp) flat_list.insert(flat_list.size(), MV_E);
      else if (xn) flat_list.insert(flat_list.size(), MV_W);
      else if (yp) flat_list.insert(flat_list.size(), MV_N);
      else flat_list.insert(flat_list.size(), MV_S);
      if (xp) cur_x++;
      if (xn) cur_x--;
      if (yp) cur_y++;
      if (yn) cur_y--;
    end

    // vertical leg
    while (cur_z != aim_z) begin
      if (cur_z < aim_z) begin
        lift_list.insert(lift_list.size(), MV_UP);
        cur_z++;
      end else begin
        lift_list.insert(lift_list.size(), MV_DOWN);
        cur_z--;
      end
    end

    plan_len = flat_list.size() + lift_list.size();
    pm.tag   = tag;
    pm.empty = 1'b0;
    pm.last  = 1'b0;

    if (plan_len == 0) begin
      pm.move  = MV_NE;
      pm.step  = '0;
      pm.empty = 1'b1;
      pm.last  = 1'b1;
      planned_moves.insert(planned_moves.size(), pm);
      return;
    end

    // interleave horizontal and vertical, skipping a list once it runs dry
    i = 0;
    j = 0;
    n = 0;
    while (i < flat_list.size() || j < lift_list.size()) begin
      if (i < flat_list.size()) begin
        pm.move = flat_list[i];
        pm.step = n[STEP_W-1:0];
        pm.last = (n == plan_len - 1);
        planned_moves.insert(planned_moves.size(), pm);
        i++;
        n++;
      end
      if (j < lift_list.size()) begin
        pm.move = lift_list[j];
        pm.step = n[STEP_W-1:0];
        pm.last = (n == plan_len - 1);
        planned_moves.insert(planned_moves.size(), pm);
        j++;
        n++;
      end
    end
  endfunction

  // one request transaction, after a random gap unless the sender is calm
  task automatic send_mission(input mission_row_t r);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.source_x    = r.sx;
    req_ch.source_y    = r.sy;
    req_ch.source_z    = r.sz;
    req_ch.goal_x      = r.gx;
    req_ch.goal_y      = r.gy;
    req_ch.goal_z      = r.gz;
    req_ch.mission_tag = r.tag;
    row_typed          = r.typed;
    row_move           = r.t_move;
    row_empty          = r.t_empty;
    req_ch.valid       = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    @(negedge clk);
  endtask

  // hold the request side off until every queued move has come out
  task automatic drain_plans();
    req_ch.valid = 1'b0;
    while (planned_moves.size() != 0) @(negedge clk);
  endtask

  // free-running clock, 2 ns period
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog on the whole run
  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("grid_move_sequence_generator: mismatch");
      $finish;
    end
  end

  // every accepted mission turns into its expected moves at that edge
  always @(posedge clk) begin
    planned_move_t pm;
    if (!rst && req_ch.valid && req_ch.ready) begin
      if (row_typed) begin
        // single-move rows are typed in, no planner involved
        pm.move  = row_move;
        pm.step  = '0;
        pm.tag   = req_ch.mission_tag;
        pm.empty = row_empty;
        pm.last  = 1'b1;
        planned_moves.insert(planned_moves.size(), pm);
      end else begin
        plan_mission(req_ch.source_x, req_ch.source_y, req_ch.source_z,
                     req_ch.goal_x, req_ch.goal_y, req_ch.goal_z, req_ch.mission_tag);
      end
    end
  end

  // result side: compare each move transaction with the oldest expectation
  always @(posedge clk) begin
    planned_move_t pm;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (planned_moves.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX) begin
          $display("unexpected move %0d step %0d tag %h empty %b last %b",
                   res_ch.move, res_ch.step_index, res_ch.mission_tag_res,
                   res_ch.empty_plan, res_ch.last);
        end
      end else begin
        pm = planned_moves.pop_front();
        if (res_ch.move !== pm.move || res_ch.step_index !== pm.step ||
            res_ch.mission_tag_res !== pm.tag || res_ch.empty_plan !== pm.empty ||
            res_ch.last !== pm.last) begin
          mismatch_count++;
          if (mismatch_count <= REPORT_MAX) begin
            $display("move diff: exp %0d/%0d/%h/%b/%b got %0d/%0d/%h/%b/%b",
                     pm.move, pm.step, pm.tag, pm.empty, pm.last,
                     res_ch.move, res_ch.step_index, res_ch.mission_tag_res,
                     res_ch.empty_plan, res_ch.last);
          end
        end
      end
      // draw the stall before the next move; calm stretches have none
      if (!sink_calm && $urandom_range(0, 63) == 0) sink_calm = 1'b1;
      else if (sink_calm && $urandom_range(0, 31) == 0) sink_calm = 1'b0;
      sink_wait = sink_calm ? 0 : $urandom_range(0, 15);
    end
  end

  // result ready follows the stall counter, changed on the falling edge
  always @(negedge clk) begin
    res_ch.ready = (sink_wait == 0);
    if (sink_wait > 0) sink_wait--;
  end

  initial begin
    mission_row_t r;
    int           kind;

    // known values on every input from time zero
    rst                = 1'b1;
    req_ch.valid       = 1'b0;
    req_ch.source_x    = '0;
    req_ch.source_y    = '0;
    req_ch.source_z    = '0;
    req_ch.goal_x      = '0;
    req_ch.goal_y      = '0;
    req_ch.goal_z      = '0;
    req_ch.mission_tag = '0;
    res_ch.ready       = 1'b0;
    row_typed          = 1'b0;
    row_move           = MV_NE;
    row_empty          = 1'b0;
    mismatch_count     = 0;
    sink_wait          = 0;
    sink_calm          = 1'b0;
    sender_calm        = 1'b0;
    cur_x = '0; cur_y = '0; cur_z = '0;
    aim_x = '0; aim_y = '0; aim_z = '0;
    plan_len = 0;

    // synchronous reset, released on a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed table
    for (int k = 0; k < DIRECTED_COUNT; k++) begin
      send_mission(DIRECTED[k]);
    end

    // let the block run completely dry once before the random part
    drain_plans();

    for (int k = 0; k < RANDOM_COUNT; k++) begin
      r.sx    = coord_t'($urandom_range(0, 15));
      r.sy    = coord_t'($urandom_range(0, 15));
      r.sz    = coord_t'($urandom_range(0, 15));
      r.gx    = coord_t'($urandom_range(0, 15));
      r.gy    = coord_t'($urandom_range(0, 15));
      r.gz    = coord_t'($urandom_range(0, 15));
      r.tag   = TAG_W'($urandom);
      r.typed = 1'b0;
      r.t_move  = MV_NE;
      r.t_empty = 1'b0;
      kind = $urandom_range(0, 19);
      case (kind)
        0: begin
          // empty plan
          r.gx = r.sx;
          r.gy = r.sy;
          r.gz = r.sz;
        end
        1, 2: begin
          // vertical only
          r.gx = r.sx;
          r.gy = r.sy;
        end
        3, 4: begin
          // horizontal only
          r.gz = r.sz;
        end
        5: begin
          // corner cells, longest legs likely
          r.sx = {4{$urandom_range(0, 1) == 1}};
          r.sy = {4{$urandom_range(0, 1) == 1}};
          r.sz = {4{$urandom_range(0, 1) == 1}};
          r.gx = ~r.sx;
          r.gy = $urandom_range(0, 1) ? ~r.sy : r.sy;
          r.gz = ~r.sz;
        end
        6: begin
          // one axis matches from the start: straight leg only
          if ($urandom_range(0, 1)) r.gx = r.sx;
          else r.gy = r.sy;
        end
        default: begin
        end
      endcase

      // swap between gapped and back-to-back stretches
      if (!sender_calm && $urandom_range(0, 31) == 0) sender_calm = 1'b1;
      else if (sender_calm && $urandom_range(0, 15) == 0) sender_calm = 1'b0;

      // now and then wait for the plan queue to empty first
      if ($urandom_range(0, 39) == 0) drain_plans();

      send_mission(r);
    end

    req_ch.valid = 1'b0;
    while (planned_moves.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatch_count == 0 && planned_moves.size() == 0) begin
      $display("grid_move_sequence_generator: match");
    end else begin
      $display("grid_move_sequence_generator: mismatch");
    end
    $finish;
  end

endmodule
